// File: src/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Types, constants and helpers shared by the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 30;

  // widths derived from the word format
  localparam int PROD_W    = 2 * WORD_BITS;       // one exact product
  localparam int SUM_W     = 2 * WORD_BITS + 2;   // sum of four products
  localparam int SQ_STEPS  = SUM_W / 2;           // root digits
  localparam int ROOT_W    = WORD_BITS + 1;
  localparam int REM_W     = ROOT_W + 3;
  localparam int DIV_STEPS = FRAC_BITS + 1;       // quotient bits
  localparam int NUM_W     = WORD_BITS + FRAC_BITS;
  localparam int DREM_W    = ROOT_W + 1;

  // command codes as they arrive
  localparam logic [2:0] CMD_MUL   = 3'd0;
  localparam logic [2:0] CMD_ROT   = 3'd1;
  localparam logic [2:0] CMD_NORM  = 3'd2;
  localparam logic [2:0] CMD_SCALE = 3'd3;
  localparam logic [2:0] CMD_CONJ  = 3'd4;

  localparam logic [1:0] IDX_W = 2'd3;  // w component

  typedef logic [WORD_BITS-1:0]       word_t;
  typedef logic [3:0][WORD_BITS-1:0]  quat_t;   // [0]=x .. [3]=w

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ROT,
    OP_NORM,
    OP_SCALE,
    OP_CONJ,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0]                  cmd;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] a_w;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] b_w;
  } qin_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] r_w;
    logic                        saturated;
  } qres_t;

  // classified item between front and back
  typedef struct packed {
    op_e   op;
    quat_t a;
    quat_t b;
  } qop_t;

  // handoff from the product stages to the normalize stages
  typedef struct packed {
    logic             act;   // normalize with nonzero norm
    qres_t            res;
    logic [3:0]       sgn;
    quat_t            mag;
    logic [SUM_W-1:0] s;
  } nrec_t;

  typedef struct packed {
    word_t v;
    logic  f;
  } sat_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic signed [SUM_W-1:0] HALF_S  = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] WMAX_S  = (SUM_W'(1) << (WORD_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] WMIN_S  = ~WMAX_S;

  // Hamilton product index tables: BIDX entry (c, k) at bit (c*4+k)*2, NEGT at bit c*4+k
  localparam logic [7:0]  AIDX_TBL = {2'd2, 2'd1, 2'd0, 2'd3};
  localparam logic [31:0] BIDX_TBL = {2'd2, 2'd1, 2'd0, 2'd3,  2'd3, 2'd0, 2'd1, 2'd2,
                                      2'd0, 2'd3, 2'd2, 2'd1,  2'd1, 2'd2, 2'd3, 2'd0};
  localparam logic [15:0] NEGT_TBL = 16'b1110_0100_0010_1000;

  function automatic logic [1:0] aidx(input logic [1:0] k);
    return AIDX_TBL[{k, 1'b0} +: 2];
  endfunction

  function automatic logic [1:0] bidx(input logic [1:0] c, input logic [1:0] k);
    return BIDX_TBL[{c, k, 1'b0} +: 2];
  endfunction

  function automatic logic negt(input logic [1:0] c, input logic [1:0] k);
    return NEGT_TBL[{c, k}];
  endfunction

  // round half up at the binary point, then clip to the word range
  function automatic sat_t rnd_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    sat_t                    r;
    t = (s + HALF_S) >>> FRAC_BITS;
    if (t > WMAX_S) begin
      r.v = WORD_MAX;
      r.f = 1'b1;
    end else if (t < WMIN_S) begin
      r.v = WORD_MIN;
      r.f = 1'b1;
    end else begin
      r.v = t[WORD_BITS-1:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

  function automatic qres_t pack_res(input quat_t q, input logic f);
    qres_t r;
    r.r_x       = q[0];
    r.r_y       = q[1];
    r.r_z       = q[2];
    r.r_w       = q[3];
    r.saturated = f;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/qau_front.sv
// ----------------------------------------------------------------------------
// qau_front
// Input queue: takes items, decodes the command and holds two classified
// items for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_front import qau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qin_t  in_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output qop_t  op_o
);

  qop_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  qop_t       cls;
  logic       push_ok, pop_ok;

  always_comb begin
    cls.a = {in_i.a_w, in_i.a_z, in_i.a_y, in_i.a_x};
    cls.b = {in_i.b_w, in_i.b_z, in_i.b_y, in_i.b_x};
    unique case (in_i.cmd)
      CMD_MUL:   cls.op = OP_MUL;
      CMD_ROT:   cls.op = OP_ROT;
      CMD_NORM:  cls.op = OP_NORM;
      CMD_SCALE: cls.op = OP_SCALE;
      CMD_CONJ:  cls.op = OP_CONJ;
      default:   cls.op = OP_NONE;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = mem_q[rp_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) wp_q <= ~wp_q;
      if (pop_ok)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) mem_q[wp_q] <= cls;
  end

endmodule

`default_nettype wire

// File: src/qau_mul.sv
// ----------------------------------------------------------------------------
// qau_mul
// Product stages: first product array, row sums with rounding, conjugate,
// second product array for rotation, final selection of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_mul import qau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  in_valid_i,
  input  qop_t  in_op_i,
  output logic  rec_valid_o,
  output nrec_t rec_o
);

  // ---------------- stage 1: product array
  word_t                    mx   [4][4];
  word_t                    my   [4][4];
  logic signed [PROD_W-1:0] p1_d [4][4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        mx[c][k] = '0;
        my[c][k] = '0;
        case (in_op_i.op)
          OP_MUL, OP_ROT: begin
            mx[c][k] = in_op_i.a[aidx(2'(k))];
            my[c][k] = in_op_i.b[bidx(2'(c), 2'(k))];
            // rotation uses the pure vector (b_w dropped)
            if (in_op_i.op == OP_ROT && bidx(2'(c), 2'(k)) == IDX_W) my[c][k] = '0;
          end
          OP_SCALE: begin
            if (k == 0) begin
              mx[c][k] = in_op_i.a[2'(c)];
              my[c][k] = in_op_i.b[0];
            end
          end
          OP_NORM: begin
            if (c == 0) begin
              mx[c][k] = in_op_i.a[2'(k)];
              my[c][k] = in_op_i.a[2'(k)];
            end
          end
          default: ;
        endcase
        p1_d[c][k] = $signed(mx[c][k]) * $signed(my[c][k]);
      end
    end
  end

  logic                     v1_q;
  op_e                      op1_q;
  quat_t                    a1_q;
  logic signed [PROD_W-1:0] p1_q [4][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv_i) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op1_q <= in_op_i.op;
      a1_q  <= in_op_i.a;
      p1_q  <= p1_d;
    end
  end

  // ---------------- stage 2: row sums, conjugate
  logic signed [SUM_W-1:0] row2 [4];
  sat_t                    rs2  [4];
  quat_t                   t2_d, ca2_d;
  logic [3:0]              tf2_d;
  logic [2:0]              cf2_d;
  logic                    neg_en;

  always_comb begin
    neg_en = (op1_q == OP_MUL) || (op1_q == OP_ROT);
    for (int c = 0; c < 4; c++) begin
      row2[c] = '0;
      for (int k = 0; k < 4; k++) begin
        if (neg_en && negt(2'(c), 2'(k))) row2[c] = row2[c] - SUM_W'(p1_q[c][k]);
        else                              row2[c] = row2[c] + SUM_W'(p1_q[c][k]);
      end
      rs2[c]   = rnd_sat(row2[c]);
      t2_d[c]  = rs2[c].v;
      tf2_d[c] = rs2[c].f;
    end
    for (int k = 0; k < 3; k++) begin
      if (a1_q[k] == WORD_MIN) begin
        ca2_d[k] = WORD_MAX;
        cf2_d[k] = 1'b1;
      end else begin
        ca2_d[k] = '0 - a1_q[k];
        cf2_d[k] = 1'b0;
      end
    end
    ca2_d[3] = a1_q[3];
  end

  logic             v2_q, tf2_q, cf2_q;
  op_e              op2_q;
  quat_t            a2_q, t2_q, ca2_q;
  logic [SUM_W-1:0] s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv_i) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op2_q <= op1_q;
      a2_q  <= a1_q;
      t2_q  <= t2_d;
      tf2_q <= |tf2_d;
      ca2_q <= ca2_d;
      cf2_q <= |cf2_d;
      s2_q  <= row2[0];   // sum of squares for normalize
    end
  end

  // ---------------- stage 3: (a*v) * conj(a)
  logic signed [PROD_W-1:0] p3_d [3][4];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        p3_d[c][k] = $signed(t2_q[aidx(2'(k))]) * $signed(ca2_q[bidx(2'(c), 2'(k))]);
      end
    end
  end

  logic                     v3_q, tf3_q, cf3_q;
  op_e                      op3_q;
  quat_t                    a3_q, t3_q, ca3_q;
  logic [SUM_W-1:0]         s3_q;
  logic signed [PROD_W-1:0] p3_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv_i) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op3_q <= op2_q;
      a3_q  <= a2_q;
      t3_q  <= t2_q;
      tf3_q <= tf2_q;
      ca3_q <= ca2_q;
      cf3_q <= cf2_q;
      s3_q  <= s2_q;
      p3_q  <= p3_d;
    end
  end

  // ---------------- stage 4: rotation sums, result select
  logic signed [SUM_W-1:0] row4 [3];
  sat_t                    rs4  [3];
  quat_t                   rot;
  logic                    rf;
  nrec_t                   rec_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      row4[c] = '0;
      for (int k = 0; k < 4; k++) begin
        if (negt(2'(c), 2'(k))) row4[c] = row4[c] - SUM_W'(p3_q[c][k]);
        else                    row4[c] = row4[c] + SUM_W'(p3_q[c][k]);
      end
      rs4[c] = rnd_sat(row4[c]);
      rot[c] = rs4[c].v;
    end
    rot[3] = '0;
    rf     = rs4[0].f | rs4[1].f | rs4[2].f;

    case (op3_q)
      OP_MUL, OP_SCALE: rec_d.res = pack_res(t3_q, tf3_q);
      OP_ROT:           rec_d.res = pack_res(rot, tf3_q | cf3_q | rf);
      OP_CONJ:          rec_d.res = pack_res(ca3_q, cf3_q);
      OP_NORM:          rec_d.res = pack_res(a3_q, 1'b0);  // kept when norm is zero
      default:          rec_d.res = pack_res('0, 1'b0);
    endcase

    rec_d.act = (op3_q == OP_NORM) && (s3_q != '0);
    rec_d.s   = s3_q;
    for (int k = 0; k < 4; k++) begin
      rec_d.sgn[k] = a3_q[k][WORD_BITS-1];
      rec_d.mag[k] = a3_q[k][WORD_BITS-1] ? ('0 - a3_q[k]) : a3_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rec_valid_o <= 1'b0;
    else if (adv_i) rec_valid_o <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) rec_o <= rec_d;
  end

endmodule

`default_nettype wire

// File: src/qau_norm.sv
// ----------------------------------------------------------------------------
// qau_norm
// Normalize stages: digit-by-digit square root, one root bit per stage,
// then four restoring dividers, one quotient bit per stage. Other items
// ride along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_norm import qau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  in_valid_i,
  input  nrec_t rec_i,
  output logic  out_valid_o,
  output qres_t res_o
);

  typedef struct packed {
    logic              act;
    qres_t             res;
    logic [3:0]        sgn;
    quat_t             mag;
    logic [SUM_W-1:0]  s;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic                          act;
    qres_t                         res;
    logic [3:0]                    sgn;
    logic [ROOT_W-1:0]             n;
    logic [3:0][NUM_W-1:0]         num;
    logic [3:0][DREM_W-1:0]        rem;
    logic [3:0][DIV_STEPS-1:0]     q;
  } dv_t;

  logic sv_q [SQ_STEPS];
  sq_t  sq_q [SQ_STEPS];
  logic dvv_q [DIV_STEPS];
  dv_t  dv_q  [DIV_STEPS];

  // ---------------- square root
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    sq_t              prev, nxt;
    logic             pv;
    logic [REM_W-1:0] rn, trial;

    if (j == 0) begin : g_first
      always_comb begin
        prev.act  = rec_i.act;
        prev.res  = rec_i.res;
        prev.sgn  = rec_i.sgn;
        prev.mag  = rec_i.mag;
        prev.s    = rec_i.s;
        prev.rem  = '0;
        prev.root = '0;
      end
      assign pv = in_valid_i;
    end else begin : g_next
      assign prev = sq_q[j-1];
      assign pv   = sv_q[j-1];
    end

    always_comb begin
      nxt   = prev;
      rn    = {prev.rem[REM_W-3:0], prev.s[2*(SQ_STEPS-1-j)+1 -: 2]};
      trial = {1'b0, prev.root, 2'b01};
      if (rn >= trial) begin
        nxt.rem  = rn - trial;
        nxt.root = {prev.root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rn;
        nxt.root = {prev.root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[j] <= 1'b0;
      else if (adv_i) sv_q[j] <= pv;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) sq_q[j] <= nxt;
    end
  end

  // ---------------- division: (|a|*2^F + n/2) / n
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    dv_t               prev, nxt;
    logic              pv;
    logic [DREM_W-1:0] rn [4];

    if (j == 0) begin : g_first
      always_comb begin
        prev.act = sq_q[SQ_STEPS-1].act;
        prev.res = sq_q[SQ_STEPS-1].res;
        prev.sgn = sq_q[SQ_STEPS-1].sgn;
        prev.n   = sq_q[SQ_STEPS-1].root;
        prev.q   = '0;
        for (int k = 0; k < 4; k++) begin
          prev.num[k] = {sq_q[SQ_STEPS-1].mag[k], {FRAC_BITS{1'b0}}}
                        + NUM_W'(sq_q[SQ_STEPS-1].root >> 1);
          // the quotient fits in DIV_STEPS bits, so the top part is below n
          prev.rem[k] = DREM_W'(prev.num[k][NUM_W-1:DIV_STEPS]);
        end
      end
      assign pv = sv_q[SQ_STEPS-1];
    end else begin : g_next
      assign prev = dv_q[j-1];
      assign pv   = dvv_q[j-1];
    end

    always_comb begin
      nxt = prev;
      for (int k = 0; k < 4; k++) begin
        rn[k] = {prev.rem[k][DREM_W-2:0], prev.num[k][DIV_STEPS-1-j]};
        if (rn[k] >= {1'b0, prev.n}) begin
          nxt.rem[k]                = rn[k] - {1'b0, prev.n};
          nxt.q[k][DIV_STEPS-1-j] = 1'b1;
        end else begin
          nxt.rem[k] = rn[k];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dvv_q[j] <= 1'b0;
      else if (adv_i) dvv_q[j] <= pv;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) dv_q[j] <= nxt;
    end
  end

  // ---------------- output register
  quat_t nq;
  qres_t res_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nq[k] = dv_q[DIV_STEPS-1].sgn[k] ? ('0 - WORD_BITS'(dv_q[DIV_STEPS-1].q[k]))
                                        : WORD_BITS'(dv_q[DIV_STEPS-1].q[k]);
    end
    if (dv_q[DIV_STEPS-1].act) res_d = pack_res(nq, 1'b0);
    else                       res_d = dv_q[DIV_STEPS-1].res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv_i) out_valid_o <= dvv_q[DIV_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) res_o <= res_d;
  end

endmodule

`default_nettype wire

// File: src/quaternion_arithmetic_unit.sv
// Datapath: input queue, four product stages, 33 square-root and 31 divide
//   stages, then the output register on res_o.
// Throughput: one item per cycle for every command; the whole datapath
//   holds while a finished result waits at the output.
// Reset (rst_ni low, asynchronous): queue and all stage valid bits clear,
//   so full is low and empty is high.
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Fixed-point quaternion multiply, vector rotate, normalize, scale and
// conjugate with saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  input  qin_t  in_i,
  output logic  full,
  output logic  empty,
  input  logic  pop,
  output qres_t res_o
);

  logic  adv;
  logic  f_valid;
  qop_t  f_op;
  logic  rec_valid;
  nrec_t rec;
  logic  out_valid;

  // the pipeline moves unless a result sits unread at the output
  assign adv   = !out_valid || pop;
  assign empty = !out_valid;

  qau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .in_i    (in_i),
    .full_o  (full),
    .pop_i   (adv),
    .valid_o (f_valid),
    .op_o    (f_op)
  );

  qau_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (f_valid),
    .in_op_i     (f_op),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  qau_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (rec_valid),
    .rec_i       (rec),
    .out_valid_o (out_valid),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// File: src/qau_checker.sv
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_checker import qau_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  push,
  input logic  full,
  input logic  empty,
  input logic  pop,
  input qres_t res_o
);

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result changed while waiting");

  // leaving reset: nothing queued, nothing to deliver
  a_rst_state: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("bad state after reset");

  // the input queue only fills up on an item
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without an item");

  // the output only drains when an item is taken
  a_empty_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result lost without pop");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);

`default_nettype wire
